### design/ffba_pkg.sv
package ffba_pkg;

  // Field widths fixed by the channel and register definitions.
  localparam int REQ_W       = 32;
  localparam int SIZE_W      = 33;
  localparam int OUT_ADDR_W  = 39;
  localparam int CFG_DATA_W  = 39;
  localparam int CFG_INDEX_W = 1;
  localparam int STATUS_W    = 3;

  // Allocation granule in bytes.
  localparam int ALIGN_BYTES = 8;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 3'd0,
    ST_ZERO_SIZE      = 3'd1,
    ST_TABLE_FULL     = 3'd2,
    ST_HEAP_EXHAUSTED = 3'd3,
    ST_INVALID_FREE   = 3'd4
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_HEAP_START = 1'b0,
    REG_HEAP_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPEND,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [OUT_ADDR_W-1:0] block_address;
    status_e               status;
  } result_t;

endpackage

### design/ffba_if.sv
// Request channel: one allocate or free command per transfer.
interface ffba_req_if import ffba_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [REQ_W-1:0]      request_bytes;
  logic [OUT_ADDR_W-1:0] release_address;

  modport source (output valid, command, request_bytes, release_address, input ready);
  modport sink   (input valid, command, request_bytes, release_address, output ready);
endinterface

// Response channel: one address and status per transfer.
interface ffba_rsp_if import ffba_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [OUT_ADDR_W-1:0] block_address;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

### design/ffba_ram.sv
module ffba_ram import ffba_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 73
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 39
) (
  input  logic                 clk,
  input  logic                 rst,
  ffba_req_if.sink             req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output result_t              res,
  input  logic [ADDR_BITS-1:0] heap_limit,
  input  logic                 bump_load,
  input  logic [ADDR_BITS-1:0] bump_value
);

  localparam int AW   = ADDR_BITS;
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int EW   = AW + SIZE_W + 1;
  localparam int CMPW = (AW > SIZE_W) ? AW : SIZE_W;

  state_e state, state_next;

  cmd_e              cmd;
  logic [SIZE_W-1:0] need;
  logic [AW-1:0]     rel_addr;
  logic [CW-1:0]     issue_idx;
  logic              rd_pending;
  logic [IW-1:0]     rd_idx;
  logic [CW-1:0]     count;
  logic [AW-1:0]     bump;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic              ram_re;
  logic [EW-1:0]     ram_rdata;

  logic [AW-1:0]     rd_start;
  logic [SIZE_W-1:0] rd_bytes;
  logic              rd_busy;
  logic              hit;
  logic              more;
  logic              zero_req;
  logic [SIZE_W-1:0] need_round;
  logic              full;
  logic              exhausted;
  logic              append_ok;

  ffba_ram #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  // Entry layout: start address, size in bytes, busy mark.
  assign rd_start = ram_rdata[EW-1 -: AW];
  assign rd_bytes = ram_rdata[SIZE_W:1];
  assign rd_busy  = ram_rdata[0];

  // Size rounded up to the allocation granule.
  assign need_round = (SIZE_W'(req.request_bytes) + SIZE_W'(ALIGN_BYTES - 1))
                      & ~SIZE_W'(ALIGN_BYTES - 1);
  assign zero_req   = (cmd_e'(req.command) == CMD_ALLOC) && (req.request_bytes == '0);

  // Scan compare on the entry that arrived from the table this cycle.
  always_comb begin
    if (!rd_pending) begin
      hit = 1'b0;
    end else if (cmd == CMD_ALLOC) begin
      hit = !rd_busy && (rd_bytes >= need);
    end else begin
      hit = rd_busy && (rd_start == rel_addr);
    end
  end

  assign more = issue_idx < count;

  // Append checks against the table size and the heap limit.
  assign full      = count == CW'(MAX_BLOCKS);
  assign exhausted = (bump > heap_limit) || (CMPW'(need) > CMPW'(heap_limit - bump));
  assign append_ok = !full && !exhausted;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = zero_req ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_RESP;
        end else if (!more && !rd_pending) begin
          state_next = (cmd == CMD_ALLOC) ? S_APPEND : S_RESP;
        end
      end
      S_APPEND: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshakes and table accesses.
  always_comb begin
    req.ready = 1'b0;
    res_valid = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = {rd_start, rd_bytes, ~rd_busy};
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_SCAN: begin
        ram_re = more;
        ram_we = hit;
      end
      S_APPEND: begin
        ram_we    = append_ok;
        ram_waddr = count[IW-1:0];
        ram_wdata = {bump, need, 1'b1};
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      bump       <= '0;
      rd_pending <= 1'b0;
      issue_idx  <= '0;
    end else begin
      state <= state_next;
      if (bump_load) begin
        bump <= bump_value;
      end else if (state == S_APPEND && append_ok) begin
        bump <= bump + AW'(need);
      end
      if (state == S_APPEND && append_ok) begin
        count <= count + CW'(1);
      end
      if (state == S_IDLE) begin
        issue_idx  <= '0;
        rd_pending <= 1'b0;
      end else if (state == S_SCAN) begin
        issue_idx  <= issue_idx + CW'(more);
        rd_pending <= more && !hit;
      end
    end
  end

  // Request payload and result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd      <= cmd_e'(req.command);
      need     <= need_round;
      rel_addr <= AW'(req.release_address);
      res      <= '{block_address: '0, status: ST_ZERO_SIZE};
    end
    if (state == S_SCAN) begin
      rd_idx <= issue_idx[IW-1:0];
      if (hit) begin
        res.status        <= ST_OK;
        res.block_address <= (cmd == CMD_ALLOC) ? OUT_ADDR_W'(rd_start) : '0;
      end else if (!more && !rd_pending) begin
        res.status        <= ST_INVALID_FREE;
        res.block_address <= '0;
      end
    end
    if (state == S_APPEND) begin
      priority if (full) begin
        res <= '{block_address: '0, status: ST_TABLE_FULL};
      end else if (exhausted) begin
        res <= '{block_address: '0, status: ST_HEAP_EXHAUSTED};
      end else begin
        res <= '{block_address: OUT_ADDR_W'(bump), status: ST_OK};
      end
    end
  end

  // The entry count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_BLOCKS))
    else $error("entry count beyond table size");

  // The table is written only while scanning or appending.
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SCAN || state == S_APPEND))
    else $error("table write outside scan or append");

  // A read in flight exists only during a scan.
  a_pending_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> state == S_SCAN)
    else $error("read pending outside scan");

  // The entry count changes only through an append.
  a_count_append: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> $past(state) == S_APPEND)
    else $error("entry count changed outside append");

endmodule

### design/first_fit_block_allocator.sv
// Path from request transfer to result: a zero-size allocate goes straight to the response,
// a match ends the scan early, a free that matches nothing ends after the whole table, and
// an allocate with no match reaches the append step (table full and heap exhausted too).
// One request at a time: the next is taken only after the result is handed to the output
// register; the scan reads one entry per cycle from the block table.
// Reset (synchronous, active high) empties the table, zeroes the bump pointer, sets the heap
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int ADDR_BITS  = 39
) (
  input  logic                   clk,
  input  logic                   rst,
  ffba_req_if.sink               req,
  ffba_rsp_if.source             rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Limit to all ones and takes requests at once, with no clearing pass.

  localparam int AW = ADDR_BITS;

  logic [AW-1:0] heap_limit;
  logic          bump_load;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          out_valid;
  result_t       out_data;

  // Register writes: the start address goes straight to the bump pointer.
  assign bump_load = cfg_we && (cfg_index == REG_HEAP_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= AW'({CFG_DATA_W{1'b1}});
    end else if (cfg_we && cfg_index == REG_HEAP_LIMIT) begin
      heap_limit <= AW'(cfg_data);
    end
  end

  ffba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .heap_limit (heap_limit),
    .bump_load  (bump_load),
    .bump_value (AW'(cfg_data))
  );

  // Output register decouples the response channel from the sequencer.
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.block_address = out_data.block_address;
  assign rsp.status        = out_data.status;

endmodule
